// ----- rtl/core/scu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scu_pkg: shared types, constants and helpers
// Binary32 constants for argument reduction and the polynomials, the
// pipeline stage record, and the leading zero counter used by the FP units.
// ----------------------------------------------------------------------------
package scu_pkg;

   localparam logic [31:0] QNAN_BITS  = 32'h7FC0_0000;
   localparam logic [31:0] FOPI_BITS  = 32'h3FA2_F983;  // 4/pi
   localparam logic [31:0] DP1_BITS   = 32'h3F49_0000;
   localparam logic [31:0] DP2_BITS   = 32'h397D_A000;
   localparam logic [31:0] DP3_BITS   = 32'h3322_2169;
   localparam logic [31:0] PIO4_BITS  = 32'h3F49_0FDB;
   localparam logic [31:0] BIG_BITS   = 32'h4600_0000;  // 8192
   localparam logic [31:0] LIMIT_BITS = 32'h4B7F_FFFF;  // 16777215
   localparam logic [31:0] INF_BITS   = 32'h7F80_0000;
   localparam logic [31:0] SIN0_BITS  = 32'hB94C_A1F9;
   localparam logic [31:0] SIN1_BITS  = 32'h3C08_839E;
   localparam logic [31:0] SIN2_BITS  = 32'hBE2A_AAA3;
   localparam logic [31:0] COS0_BITS  = 32'h37CC_F5CE;
   localparam logic [31:0] COS1_BITS  = 32'hBAB6_061A;
   localparam logic [31:0] COS2_BITS  = 32'h3D2A_AAA5;
   localparam logic [31:0] HALF_BITS  = 32'h3F00_0000;
   localparam logic [31:0] ONE_BITS   = 32'h3F80_0000;
   localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;

   localparam logic [1:0] SPEC_NONE = 2'd0;
   localparam logic [1:0] SPEC_NAN  = 2'd1;
   localparam logic [1:0] SPEC_ZERO = 2'd2;

   typedef struct packed {
      logic        cmd;
      logic [1:0]  spec;
      logic        neg;
      logic        cos_sel;
      logic        big;
      logic [24:0] oct;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] r;
      logic [31:0] z;
      logic [31:0] acc;
   } pipe_type;

   function automatic logic [6:0] lzc64(input logic [63:0] v);
      logic [6:0] n;
      logic       found;
      n     = '0;
      found = 1'b0;
      for (int i = 63; i >= 0; i--) begin
         if (!found) begin
            if (v[i]) found = 1'b1;
            else n = n + 7'd1;
         end
      end
      return n;
   endfunction

endpackage

// ----- rtl/core/scu_fmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scu_fmul: binary32 multiplier
// Combinational product with subnormal support, round to nearest even.
// ----------------------------------------------------------------------------
module scu_fmul (
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [31:0] prod
);

   logic               sgn;
   logic [7:0]         ea, eb;
   logic [23:0]        ma, mb;
   logic [47:0]        p, q, mask;
   logic [6:0]         lz;
   logic signed [11:0] esum, e_norm, shl, rsh;
   logic [11:0]        ebase;
   logic               st_x, rnd;
   logic [23:0]        m24;
   logic [33:0]        pk;

   always_comb begin
      sgn  = op_a[31] ^ op_b[31];
      ea   = (op_a[30:23] == 8'd0) ? 8'd1 : op_a[30:23];
      eb   = (op_b[30:23] == 8'd0) ? 8'd1 : op_b[30:23];
      ma   = {(op_a[30:23] != 8'd0), op_a[22:0]};
      mb   = {(op_b[30:23] != 8'd0), op_b[22:0]};
      p    = ma * mb;
      lz   = scu_pkg::lzc64({p, 16'hFFFF});
      esum = 12'(ea) + 12'(eb);
      e_norm = esum - 12'sd126 - $signed(12'(lz));
      // subnormal result: shift so the field lands at the 2^-149 scale
      if (e_norm >= 12'sd1) shl = $signed(12'(lz));
      else shl = esum - 12'sd127;
      q    = '0;
      st_x = 1'b0;
      rsh  = '0;
      mask = '0;
      if (shl >= 12'sd0) begin
         q = p << shl[5:0];
      end else begin
         rsh = -shl;
         if (rsh >= 12'sd48) begin
            st_x = |p;
         end else begin
            q    = p >> rsh[5:0];
            mask = (48'd1 << rsh[5:0]) - 48'd1;
            st_x = |(p & mask);
         end
      end
      m24   = q[47:24];
      rnd   = q[23] & ((|q[22:0]) | st_x | m24[0]);
      ebase = (e_norm >= 12'sd1) ? 12'(e_norm - 12'sd1) : 12'd0;
      pk    = (34'(ebase) << 23) + 34'(m24) + 34'(rnd);
      if (p == 48'd0) prod = {sgn, 31'd0};
      else if (pk >= 34'(scu_pkg::INF_BITS)) prod = {sgn, scu_pkg::INF_BITS[30:0]};
      else prod = {sgn, pk[30:0]};
   end

endmodule

// ----- rtl/core/scu_fadd.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scu_fadd: binary32 adder
// Combinational sum with subnormal support, round to nearest even.
// ----------------------------------------------------------------------------
module scu_fadd (
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [31:0] sum
);

   logic [31:0] big_op, sml_op;
   logic [7:0]  e_big, e_sml, d, lim, sh;
   logic [26:0] m_big, m_sml, m_shf, mask, sn;
   logic [27:0] s28;
   logic [6:0]  lz;
   logic [8:0]  en;
   logic [23:0] m24;
   logic        rnd;
   logic [33:0] pk;

   always_comb begin
      if (op_a[30:0] >= op_b[30:0]) begin
         big_op = op_a;
         sml_op = op_b;
      end else begin
         big_op = op_b;
         sml_op = op_a;
      end
      e_big = (big_op[30:23] == 8'd0) ? 8'd1 : big_op[30:23];
      e_sml = (sml_op[30:23] == 8'd0) ? 8'd1 : sml_op[30:23];
      m_big = {(big_op[30:23] != 8'd0), big_op[22:0], 3'b000};
      m_sml = {(sml_op[30:23] != 8'd0), sml_op[22:0], 3'b000};
      d     = e_big - e_sml;
      mask  = '0;
      if (d >= 8'd27) begin
         m_shf = {26'd0, |m_sml};
      end else begin
         mask  = (27'd1 << d[4:0]) - 27'd1;
         m_shf = (m_sml >> d[4:0]) | {26'd0, |(m_sml & mask)};
      end
      if (big_op[31] ^ sml_op[31]) s28 = {1'b0, m_big} - {1'b0, m_shf};
      else s28 = {1'b0, m_big} + {1'b0, m_shf};
      lz  = scu_pkg::lzc64({s28[26:0], {37{1'b1}}});
      lim = e_big - 8'd1;
      sh  = '0;
      if (s28[27]) begin
         sn = {s28[27:2], s28[1] | s28[0]};
         en = 9'(e_big) + 9'd1;
      end else begin
         // stop the left shift at the subnormal boundary
         sh = (8'(lz) < lim) ? 8'(lz) : lim;
         sn = s28[26:0] << sh[4:0];
         en = 9'(e_big) - 9'(sh);
      end
      m24 = sn[26:3];
      rnd = sn[2] & (sn[1] | sn[0] | m24[0]);
      pk  = ((34'(en) - 34'd1) << 23) + 34'(m24) + 34'(rnd);
      if (s28 == 28'd0) sum = {big_op[31] & sml_op[31], 31'd0};
      else if (pk >= 34'(scu_pkg::INF_BITS)) sum = {big_op[31], scu_pkg::INF_BITS[30:0]};
      else sum = {big_op[31], pk[30:0]};
   end

endmodule

// ----- rtl/core/binary32_sine_cosine_unit_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary32_sine_cosine_unit_core: pipelined binary32 sine / cosine
// Octant from 4/pi*|x|, Cody-Waite reduction (one pi/4 step above 8192),
// polynomials in r*r, each step a separately rounded binary32 operation.
// ----------------------------------------------------------------------------
// A new request can be accepted every clock cycle while req_stall is low;
// each request passes through every register stage before its result appears
// on rsp_valid, most stages holding a floating point multiply or add of the
// evaluation chain. Results come back in request order. Stages that are empty
// absorb a stall, so the input keeps taking requests until every stage holds a
// request; a NaN or infinite operand returns 0x7FC00000 and a magnitude above
// 16777215 returns +0.
module binary32_sine_cosine_unit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [31:0] req_operand,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result
);

   localparam int NS    = 20;
   localparam int N_MUL = 10;
   localparam int N_ADD = 7;

   scu_pkg::pipe_type stg_ff [NS];
   scu_pkg::pipe_type stg_in [NS];
   logic [NS-1:0]     vld_ff;
   logic [NS-1:0]     vld_in;
   logic [NS-1:0]     load;

   logic [31:0] mul_a [N_MUL];
   logic [31:0] mul_b [N_MUL];
   logic [31:0] mul_y [N_MUL];
   logic [31:0] add_a [N_ADD];
   logic [31:0] add_b [N_ADD];
   logic [31:0] add_y [N_ADD];

   logic [30:0] mag;
   logic [7:0]  t_exp;
   logic [7:0]  t_sh;
   logic [25:0] octb;
   logic [25:0] octn;
   logic [6:0]  oct_lz;

   for (genvar i = 0; i < N_MUL; i++) begin : g_mul
      scu_fmul u_mul (.op_a(mul_a[i]), .op_b(mul_b[i]), .prod(mul_y[i]));
   end
   for (genvar i = 0; i < N_ADD; i++) begin : g_add
      scu_fadd u_add (.op_a(add_a[i]), .op_b(add_b[i]), .sum(add_y[i]));
   end

   // stage operands
   always_comb begin
      mul_a[0] = scu_pkg::FOPI_BITS;  mul_b[0] = stg_ff[0].x;
      mul_a[1] = stg_ff[3].y;
      mul_b[1] = stg_ff[3].big ? scu_pkg::PIO4_BITS : scu_pkg::DP1_BITS;
      mul_a[2] = stg_ff[5].y;         mul_b[2] = scu_pkg::DP2_BITS;
      mul_a[3] = stg_ff[7].y;         mul_b[3] = scu_pkg::DP3_BITS;
      mul_a[4] = stg_ff[9].r;         mul_b[4] = stg_ff[9].r;
      mul_a[5] = stg_ff[10].cos_sel ? scu_pkg::COS0_BITS : scu_pkg::SIN0_BITS;
      mul_b[5] = stg_ff[10].z;
      mul_a[6] = stg_ff[12].acc;      mul_b[6] = stg_ff[12].z;
      mul_a[7] = stg_ff[14].acc;      mul_b[7] = stg_ff[14].z;
      mul_a[8] = stg_ff[15].acc;
      mul_b[8] = stg_ff[15].cos_sel ? stg_ff[15].z : stg_ff[15].r;
      mul_a[9] = scu_pkg::HALF_BITS;  mul_b[9] = stg_ff[15].z;

      add_a[0] = stg_ff[4].x;         add_b[0] = stg_ff[4].acc ^ scu_pkg::SIGN_BIT;
      add_a[1] = stg_ff[6].r;         add_b[1] = stg_ff[6].acc ^ scu_pkg::SIGN_BIT;
      add_a[2] = stg_ff[8].r;         add_b[2] = stg_ff[8].acc ^ scu_pkg::SIGN_BIT;
      add_a[3] = stg_ff[11].acc;
      add_b[3] = stg_ff[11].cos_sel ? scu_pkg::COS1_BITS : scu_pkg::SIN1_BITS;
      add_a[4] = stg_ff[13].acc;
      add_b[4] = stg_ff[13].cos_sel ? scu_pkg::COS2_BITS : scu_pkg::SIN2_BITS;
      add_a[5] = stg_ff[16].acc;
      add_b[5] = stg_ff[16].cos_sel ? (stg_ff[16].y ^ scu_pkg::SIGN_BIT) : stg_ff[16].r;
      add_a[6] = stg_ff[17].acc;      add_b[6] = scu_pkg::ONE_BITS;
   end

   // next values of every stage
   always_comb begin
      for (int k = 1; k < NS; k++) begin
         stg_in[k] = stg_ff[k-1];
      end

      // decode
      mag = req_operand[30:0];
      stg_in[0]      = '0;
      stg_in[0].cmd  = req_cmd;
      stg_in[0].neg  = !req_cmd && req_operand[31] && (mag != 31'd0);
      stg_in[0].x    = {1'b0, mag};
      if (mag >= scu_pkg::INF_BITS[30:0]) stg_in[0].spec = scu_pkg::SPEC_NAN;
      else if (mag > scu_pkg::LIMIT_BITS[30:0]) stg_in[0].spec = scu_pkg::SPEC_ZERO;
      else stg_in[0].spec = scu_pkg::SPEC_NONE;

      stg_in[1].acc = mul_y[0];

      // truncate 4/pi*|x| to an integer
      t_exp = stg_ff[1].acc[30:23];
      t_sh  = t_exp - 8'd127;
      if (t_exp < 8'd127) stg_in[2].oct = '0;
      else if (t_sh <= 8'd23)
         stg_in[2].oct = 25'({1'b1, stg_ff[1].acc[22:0]} >> (5'd23 - t_sh[4:0]));
      else stg_in[2].oct = {1'b1, stg_ff[1].acc[22:0], 1'b0};

      // bump odd octant, back to float (exact), octant flags
      octb   = 26'(stg_ff[2].oct) + 26'(stg_ff[2].oct[0]);
      oct_lz = scu_pkg::lzc64({octb, {38{1'b1}}});
      octn   = octb << oct_lz[4:0];
      if (octb == 26'd0) stg_in[3].y = '0;
      else stg_in[3].y = {1'b0, 8'(8'd152 - 8'(oct_lz)), octn[24:2]};
      stg_in[3].neg     = stg_ff[2].neg ^ octb[2] ^ (stg_ff[2].cmd & octb[1]);
      stg_in[3].cos_sel = octb[1] ^ octb[0] ^ stg_ff[2].cmd;
      stg_in[3].big     = stg_ff[2].x > scu_pkg::BIG_BITS;

      stg_in[4].acc = mul_y[1];
      stg_in[5].r   = add_y[0];
      stg_in[6].acc = mul_y[2];
      if (!stg_ff[6].big) stg_in[7].r = add_y[1];
      stg_in[8].acc = mul_y[3];
      if (!stg_ff[8].big) stg_in[9].r = add_y[2];
      stg_in[10].z   = mul_y[4];
      stg_in[11].acc = mul_y[5];
      stg_in[12].acc = add_y[3];
      stg_in[13].acc = mul_y[6];
      stg_in[14].acc = add_y[4];
      stg_in[15].acc = mul_y[7];
      stg_in[16].acc = mul_y[8];
      stg_in[16].y   = mul_y[9];
      stg_in[17].acc = add_y[5];
      if (stg_ff[17].cos_sel) stg_in[18].acc = add_y[6];

      // result: specials and sign
      case (stg_ff[18].spec)
         scu_pkg::SPEC_NAN:  stg_in[19].acc = scu_pkg::QNAN_BITS;
         scu_pkg::SPEC_ZERO: stg_in[19].acc = '0;
         default: begin
            stg_in[19].acc = stg_ff[18].acc ^ {stg_ff[18].neg, 31'd0};
         end
      endcase
   end

   // per-stage advance: a stage loads when empty or when its content moves on
   always_comb begin
      load[NS-1] = !vld_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         load[k] = !vld_ff[k] || load[k+1];
      end
      vld_in = {vld_ff[NS-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (load[k]) vld_ff[k] <= vld_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (load[k]) stg_ff[k] <= stg_in[k];
      end
   end

   assign req_stall  = !load[0];
   assign rsp_valid  = vld_ff[NS-1];
   assign rsp_result = stg_ff[NS-1].acc;

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff))
      else $error("input stalled with an empty stage");

   a_flow_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output drains");

   a_nan_result: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NS-2] && load[NS-1] && stg_ff[NS-2].spec == scu_pkg::SPEC_NAN)
         |=> (rsp_result == scu_pkg::QNAN_BITS))
      else $error("NaN request did not give quiet NaN");

endmodule

// ----- verif/binary32_sine_cosine_unit_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary32_sine_cosine_unit_core_tb: self-checking bench for the sin/cos core
// Drives a table of directed requests followed by random operands, all in bursts,
// stalls the result side on a changing pattern, and checks every result against
// the table value where given, else a bit-exact binary32 soft-float evaluation.
// ----------------------------------------------------------------------------
module binary32_sine_cosine_unit_core_tb;

   localparam int N_RANDOM   = 550;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYC  = 30;

   typedef struct {
      logic        cmd;
      logic [31:0] operand;
      logic        typed;    // expected value given in the table
      logic [31:0] result;
   } trig_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = 1'b0;
   logic [31:0] req_operand = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_result;

   trig_req_type stim_q[$];
   logic [31:0]  expected_results[$];
   trig_req_type cur;
   logic         took = 1'b0;
   int           idle_cycles = 0;
   int           n_fail = 0;
   int           cyc = 0;

   binary32_sine_cosine_unit_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_operand (req_operand),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_result  (rsp_result)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- binary32 soft float, round to nearest even ----------------
   // value = m * 2^e, rounded and packed
   function automatic logic [31:0] fp_pack(logic sgn, int e, logic [63:0] m);
      int           p, sh, k, bexp;
      logic [127:0] wm, s, rem, half;
      if (m == 0) return {sgn, 31'b0};
      p = 63;
      while (!m[p]) p--;
      sh = p - 23;
      if (sh < -(e + 149)) sh = -(e + 149);
      wm = {64'b0, m};
      if (sh > 0) begin
         if (sh > 120) begin
            s = '0;
         end else begin
            s    = wm >> sh;
            rem  = wm - (s << sh);
            half = 128'b1 << (sh - 1);
            if (rem > half || (rem == half && s[0])) s = s + 1;
         end
      end else begin
         s = wm << (-sh);
      end
      k = e + sh;
      if (s[24]) begin
         s = s >> 1;
         k++;
      end
      if (s[23]) begin
         bexp = k + 150;
         if (bexp >= 255) return {sgn, 8'hFF, 23'b0};
         return {sgn, bexp[7:0], s[22:0]};
      end
      return {sgn, 8'b0, s[22:0]};
   endfunction

   function automatic void fp_unpack(input logic [31:0] a, output logic [63:0] m,
                                     output int e);
      if (a[30:23] == 0) begin
         m = {41'b0, a[22:0]};
         e = -149;
      end else begin
         m = {40'b0, 1'b1, a[22:0]};
         e = int'(a[30:23]) - 150;
      end
   endfunction

   function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
      logic [63:0] ma, mb;
      int          ea, eb;
      fp_unpack(a, ma, ea);
      fp_unpack(b, mb, eb);
      return fp_pack(a[31] ^ b[31], ea + eb, ma * mb);
   endfunction

   function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
      logic [63:0] ma, mb, big, sml, m;
      logic        sa, sb, sgn;
      int          ea, eb, d;
      if (int'(a[30:23]) < int'(b[30:23])) begin
         fp_unpack(b, ma, ea);
         fp_unpack(a, mb, eb);
         sa = b[31];
         sb = a[31];
      end else begin
         fp_unpack(a, ma, ea);
         fp_unpack(b, mb, eb);
         sa = a[31];
         sb = b[31];
      end
      d   = ea - eb;
      big = ma << 38;
      sml = mb << 38;
      // bits shifted out of the smaller operand fold into a sticky lsb
      if (d >= 63) sml = (mb != 0) ? 64'd1 : 64'd0;
      else if (d > 0) sml = (sml >> d) | ((sml & ((64'd1 << d) - 1)) != 0);
      if (sa == sb) begin
         m   = big + sml;
         sgn = sa;
      end else if (big >= sml) begin
         m   = big - sml;
         sgn = sa;
      end else begin
         m   = sml - big;
         sgn = sb;
      end
      if (m == 0 && sa != sb) sgn = 1'b0;
      return fp_pack(sgn, ea - 38, m);
   endfunction

   function automatic logic [31:0] fp_sub(logic [31:0] a, logic [31:0] b);
      return fp_add(a, b ^ scu_pkg::SIGN_BIT);
   endfunction

   function automatic logic [31:0] fp_trunc_uint(logic [31:0] a);
      logic [63:0] m;
      int          sh;
      if (a[30:23] < 8'd127) return '0;
      m  = {40'b0, 1'b1, a[22:0]};
      sh = int'(a[30:23]) - 150;
      return (sh >= 0) ? 32'(m << sh) : 32'(m >> (-sh));
   endfunction

   function automatic logic [31:0] horner3(logic [31:0] c0, logic [31:0] c1,
                                           logic [31:0] c2, logic [31:0] v);
      logic [31:0] y;
      y = fp_add(fp_mul(c0, v), c1);
      return fp_add(fp_mul(y, v), c2);
   endfunction

   function automatic logic [31:0] sincos_expected(logic cmd, logic [31:0] xb);
      logic [31:0] x, y, r, z, oct;
      logic        neg, use_cos;
      if (xb[30:0] >= scu_pkg::INF_BITS[30:0]) return scu_pkg::QNAN_BITS;
      neg = !cmd && xb[31] && xb[30:0] != 0;
      // minus zero keeps its sign through the reduction
      x = (xb[31] && xb[30:0] != 0) ? {1'b0, xb[30:0]} : xb;
      if (x[30:0] > scu_pkg::LIMIT_BITS[30:0]) return '0;
      oct = fp_trunc_uint(fp_mul(scu_pkg::FOPI_BITS, x));
      y   = fp_pack(1'b0, 0, {32'b0, oct});
      if (oct[0]) begin
         oct = oct + 1;
         y   = fp_add(y, scu_pkg::ONE_BITS);
      end
      oct = oct & 32'd7;
      if (oct > 3) begin
         neg = !neg;
         oct = oct - 4;
      end
      if (cmd && oct > 1) neg = !neg;
      if (x[30:0] > scu_pkg::BIG_BITS[30:0]) begin
         r = fp_sub(x, fp_mul(y, scu_pkg::PIO4_BITS));
      end else begin
         r = fp_sub(x, fp_mul(y, scu_pkg::DP1_BITS));
         r = fp_sub(r, fp_mul(y, scu_pkg::DP2_BITS));
         r = fp_sub(r, fp_mul(y, scu_pkg::DP3_BITS));
      end
      z       = fp_mul(r, r);
      use_cos = (oct == 1 || oct == 2) ^ cmd;
      if (use_cos) begin
         y = horner3(scu_pkg::COS0_BITS, scu_pkg::COS1_BITS, scu_pkg::COS2_BITS, z);
         y = fp_mul(fp_mul(y, z), z);
         y = fp_sub(y, fp_mul(scu_pkg::HALF_BITS, z));
         y = fp_add(y, scu_pkg::ONE_BITS);
      end else begin
         y = horner3(scu_pkg::SIN0_BITS, scu_pkg::SIN1_BITS, scu_pkg::SIN2_BITS, z);
         y = fp_mul(fp_mul(y, z), r);
         y = fp_add(y, r);
      end
      return neg ? (y ^ scu_pkg::SIGN_BIT) : y;
   endfunction

   // ---------------- stimulus ----------------
   function automatic trig_req_type mk(logic cmd, logic [31:0] op, logic typed,
                                       logic [31:0] res);
      trig_req_type t;
      t.cmd     = cmd;
      t.operand = op;
      t.typed   = typed;
      t.result  = res;
      return t;
   endfunction

   function automatic logic [31:0] rand_operand();
      logic [7:0] ex;
      int         kind;
      kind = $urandom_range(0, 99);
      if (kind < 15)      return $urandom();
      else if (kind < 55) ex = 8'($urandom_range(110, 130));
      else if (kind < 75) ex = 8'($urandom_range(127, 140));
      else if (kind < 90) ex = 8'($urandom_range(140, 151));
      else if (kind < 95) ex = 8'($urandom_range(0, 109));
      else                ex = 8'($urandom_range(0, 1) ? 255 : 151);
      return {1'($urandom()), ex, 23'($urandom())};
   endfunction

   initial begin
      trig_req_type rows[$];
      rows = '{
         mk(1'b0, 32'h0000_0000,        1'b1, 32'h0000_0000),
         mk(1'b1, 32'h0000_0000,        1'b1, scu_pkg::ONE_BITS),
         mk(1'b0, 32'h8000_0000,        1'b0, '0),
         mk(1'b1, 32'h8000_0000,        1'b0, '0),
         mk(1'b0, scu_pkg::INF_BITS,    1'b1, scu_pkg::QNAN_BITS),
         mk(1'b1, 32'hFF80_0000,        1'b1, scu_pkg::QNAN_BITS),
         mk(1'b0, 32'h7FC0_0000,        1'b1, scu_pkg::QNAN_BITS),
         mk(1'b1, 32'h7F80_0001,        1'b1, scu_pkg::QNAN_BITS),
         mk(1'b0, 32'hFFFF_FFFF,        1'b1, scu_pkg::QNAN_BITS),
         mk(1'b0, 32'h4B80_0000,        1'b1, 32'h0000_0000),
         mk(1'b1, 32'hCB80_0000,        1'b1, 32'h0000_0000),
         mk(1'b0, 32'h7F7F_FFFF,        1'b1, 32'h0000_0000),
         mk(1'b0, scu_pkg::LIMIT_BITS,  1'b0, '0),
         mk(1'b1, 32'hCB7F_FFFF,        1'b0, '0),
         mk(1'b0, scu_pkg::BIG_BITS,    1'b0, '0),
         mk(1'b1, 32'h4600_0001,        1'b0, '0),
         mk(1'b0, 32'h0000_0001,        1'b0, '0),
         mk(1'b1, 32'h8000_0001,        1'b0, '0),
         mk(1'b0, scu_pkg::ONE_BITS,    1'b0, '0),
         mk(1'b1, scu_pkg::PIO4_BITS,   1'b0, '0),
         mk(1'b0, 32'h4049_0FDB,        1'b0, '0),
         mk(1'b1, 32'hC049_0FDB,        1'b0, '0),
         mk(1'b0, 32'hC0C9_0FDB,        1'b0, '0),
         mk(1'b1, 32'h3FC9_0FDB,        1'b0, '0)
      };
      foreach (rows[i]) stim_q.push_back(rows[i]);
      for (int i = 0; i < N_RANDOM; i++)
         stim_q.push_back(mk(1'($urandom()), rand_operand(), 1'b0, '0));
   end

   // sender: bursts of random length separated by random gaps
   initial begin
      int burst, gap;
      burst = 0;
      gap   = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      while (stim_q.size() != 0 || req_valid) begin
         @(negedge clock);
         if (!req_valid || took) begin
            if (stim_q.size() != 0 && gap == 0) begin
               cur         = stim_q.pop_front();
               req_cmd     = cur.cmd;
               req_operand = cur.operand;
               req_valid   = 1'b1;
               if (burst > 0) burst--;
               if (burst == 0) begin
                  burst = $urandom_range(1, 40);
                  gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid = 1'b0;
               if (gap > 0) gap--;
            end
         end
      end
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (n_fail == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   // receiver stall pattern steps through four modes in turn
   always @(negedge clock) begin
      cyc <= cyc + 1;
      case ((cyc / 97) % 4)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) < 7);
         default: rsp_stall <= ((cyc % 7) < 3);
      endcase
   end

   // acceptance, checking and watchdog
   always @(posedge clock) begin
      logic rsp_take;
      took     = req_valid && !req_stall && !reset;
      rsp_take = rsp_valid && !rsp_stall && !reset;
      if (took)
         expected_results.push_back(cur.typed ? cur.result
                                              : sincos_expected(req_cmd, req_operand));
      if (rsp_take) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_result);
            n_fail++;
         end else begin
            logic [31:0] want;
            want = expected_results.pop_front();
            if (rsp_result !== want) begin
               $display("%0t: result mismatch, expected %h, actual %h",
                        $time, want, rsp_result);
               n_fail++;
            end
         end
      end
      if (took || rsp_take || reset) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding",
                  $time, expected_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule

// ----- sim.f -----
rtl/core/scu_pkg.sv
rtl/core/scu_fmul.sv
rtl/core/scu_fadd.sv
rtl/core/binary32_sine_cosine_unit_core.sv
verif/binary32_sine_cosine_unit_core_tb.sv
